// ----- sv/csmu_pkg.sv -----
// Package: shared constants, codes and transaction types for the checked stack memory unit.
`timescale 1ns / 1ps
`default_nettype none

package csmu_pkg;

   // Memory geometry and transfer size
   localparam int ADDR_BITS = 16;
   localparam int MAX_BYTES = 8;
   localparam logic [32:0] MEM_DEPTH = 33'(1) << ADDR_BITS;

   // Field widths fixed by the interface
   localparam int PTR_W   = 16;
   localparam int CNT_W   = 4;
   localparam int DATA_W  = 64;
   localparam int LIM_W   = 17;
   localparam int LANES   = DATA_W / 8;

   // Request kinds
   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_STORE = 2'd2;
   localparam logic [1:0] KIND_LOAD  = 2'd3;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_STACK_LOW  = 2'd0;
   localparam logic [1:0] REG_STACK_HIGH = 2'd1;
   localparam logic [1:0] REG_MEM_LIMIT  = 2'd2;

   // Result status
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [DATA_W-1:0] write_data;
      logic [CNT_W-1:0]  byte_count;
      logic [PTR_W-1:0]  address;
      logic [PTR_W-1:0]  stack_ptr;
      logic [PTR_W-1:0]  frame_base;
   } csmu_req_type;

   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] read_data;
      logic [PTR_W-1:0]  new_stack_ptr;
   } csmu_rsp_type;

endpackage

`default_nettype wire

// ----- sv/checked_stack_memory_unit.sv -----
// Top level: bounds-checked byte memory with push/pop stack and store/load access.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake                 payload
//  req       in         req_valid / req_stall     req_data (csmu_req_type)
//  rsp       out        rsp_valid / rsp_stall     rsp_data (csmu_rsp_type)
//  csr       in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  After reset a clearing pass zeroes all 2^ADDR_BITS (65536) bytes of the
//  memory while req_stall is held high; register writes are taken meanwhile.
//  An accepted request passes a check state, then, unless it is rejected or
//  moves no bytes, a move state that takes one byte per cycle through the
//  single byte-wide memory port, then a read drain state for pop and load,
//  a result state and the idle state before the next acceptance. A result
//  waits in the output register while rsp_stall is high; a new request may
//  be accepted meanwhile, and its result state waits until the register is free.

module checked_stack_memory_unit (
   input  wire                            clock,
   input  wire                            reset,
   // request channel
   input  wire                            req_valid,
   output logic                           req_stall,
   input  csmu_pkg::csmu_req_type         req_data,
   // result channel
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output csmu_pkg::csmu_rsp_type         rsp_data,
   // register port
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire [csmu_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire [31:0]                     pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import csmu_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MOVE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Control state
   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rd_pend_ff, rd_pend_in;

   // Configuration
   logic [PTR_W-1:0]        low_ff, low_in;
   logic [PTR_W-1:0]        high_ff, high_in;
   logic [LIM_W-1:0]        lim_ff, lim_in;

   // Request working registers
   logic [1:0]              kind_ff, kind_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        addr_ff, addr_in;
   logic [PTR_W-1:0]        sp_ff, sp_in;
   logic [PTR_W-1:0]        fb_ff, fb_in;
   logic [DATA_W-1:0]       wdata_ff, wdata_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        rd_lane_ff, rd_lane_in;
   logic [DATA_W-1:0]       rdata_ff, rdata_in;
   logic                    ok_ff, ok_in;
   logic [PTR_W-1:0]        nsp_ff, nsp_in;
   csmu_rsp_type            rsp_ff, rsp_in;

   // Byte memory
   logic [7:0]              mem [0:(2**ADDR_BITS)-1];
   logic [7:0]              mem_q_ff;
   logic                    mem_we;
   logic [ADDR_BITS-1:0]    mem_waddr;
   logic [7:0]              mem_wbyte;
   logic [ADDR_BITS-1:0]    mem_raddr;

   // Shared adder and bounds checks
   logic [PTR_W+1:0]        sum;
   logic [LIM_W-1:0]        end17;
   logic                    cnt_ok, frame_ok, push_ok, pop_ok, mem_ok, req_ok;
   logic                    is_stack, is_read, last_byte;
   logic                    csr_wr;
   logic [1:0]              csr_idx;

   assign is_stack  = (kind_ff == KIND_PUSH) || (kind_ff == KIND_POP);
   assign is_read   = (kind_ff == KIND_POP) || (kind_ff == KIND_LOAD);
   assign last_byte = (k_ff == count_ff - CNT_W'(1));

   // One adder: sp - count for push, sp + count for pop, address + count for store and load
   always_comb begin
      if (kind_ff == KIND_PUSH) begin
         sum = {2'b00, sp_ff} - {{(PTR_W+2-CNT_W){1'b0}}, count_ff};
      end else begin
         sum = {2'b00, (is_stack ? sp_ff : addr_ff)}
             + {{(PTR_W+2-CNT_W){1'b0}}, count_ff};
      end
   end
   assign end17 = sum[LIM_W-1:0];

   assign cnt_ok   = (count_ff <= CNT_W'(MAX_BYTES));
   assign frame_ok = (sp_ff <= fb_ff) && (sp_ff >= low_ff) && (fb_ff < high_ff);
   assign push_ok  = frame_ok && !sum[PTR_W+1] && (sum[PTR_W-1:0] < fb_ff)
                   && (sum[PTR_W-1:0] >= low_ff);
   assign pop_ok   = frame_ok && (end17 <= {1'b0, fb_ff})
                   && (end17 >= {1'b0, low_ff}) && (end17 <= {1'b0, high_ff});
   assign mem_ok   = (end17 <= lim_ff) && (33'(end17) <= MEM_DEPTH);

   always_comb begin
      case (kind_ff)
         KIND_PUSH: req_ok = cnt_ok && push_ok;
         KIND_POP:  req_ok = cnt_ok && pop_ok;
         default:   req_ok = cnt_ok && mem_ok;
      endcase
   end

   // Register port decode
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_STACK_LOW:  prdata = {{(32-PTR_W){1'b0}}, low_ff};
         REG_STACK_HIGH: prdata = {{(32-PTR_W){1'b0}}, high_ff};
         REG_MEM_LIMIT:  prdata = {{(32-LIM_W){1'b0}}, lim_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Handshake outputs
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Memory port select
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ADDR_BITS'(ptr_ff);
      mem_wbyte = 8'd0;
      mem_raddr = ADDR_BITS'(ptr_ff);
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (state_ff == ST_MOVE) begin
         mem_we = (kind_ff != KIND_LOAD);
         if ((kind_ff == KIND_PUSH) || (kind_ff == KIND_STORE)) begin
            mem_wbyte = wdata_ff[7:0];
         end
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_pend_in   = 1'b0;
      low_in       = low_ff;
      high_in      = high_ff;
      lim_in       = lim_ff;
      kind_in      = kind_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      sp_in        = sp_ff;
      fb_in        = fb_ff;
      wdata_in     = wdata_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      rd_lane_in   = rd_lane_ff;
      rdata_in     = rdata_ff;
      ok_in        = ok_ff;
      nsp_in       = nsp_ff;
      rsp_in       = rsp_ff;

      // register writes
      if (csr_wr) begin
         case (csr_idx)
            REG_STACK_LOW:  low_in  = pwdata[PTR_W-1:0];
            REG_STACK_HIGH: high_in = pwdata[PTR_W-1:0];
            REG_MEM_LIMIT:  lim_in  = pwdata[LIM_W-1:0];
            default: ;
         endcase
      end

      // result leaves the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // read data from the previous cycle lands in its lane
      if (rd_pend_ff) begin
         for (int i = 0; i < LANES; i++) begin
            if (rd_lane_ff == CNT_W'(i)) begin
               rdata_in[8*i +: 8] = mem_q_ff;
            end
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.req_type;
               count_in = req_data.byte_count;
               addr_in  = req_data.address;
               sp_in    = req_data.stack_ptr;
               fb_in    = req_data.frame_base;
               wdata_in = req_data.write_data;
               rdata_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ok_in  = req_ok;
            nsp_in = (req_ok && is_stack) ? sum[PTR_W-1:0] : sp_ff;
            k_in   = '0;
            case (kind_ff)
               KIND_PUSH: ptr_in = sp_ff;
               KIND_POP:  ptr_in = sp_ff + PTR_W'(1);
               default:   ptr_in = addr_ff;
            endcase
            if (req_ok && (count_ff != '0)) begin
               state_in = ST_MOVE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            // one byte per cycle
            rd_pend_in = is_read;
            rd_lane_in = (kind_ff == KIND_POP) ? (count_ff - CNT_W'(1) - k_ff) : k_ff;
            wdata_in   = wdata_ff >> 8;
            ptr_in     = (kind_ff == KIND_PUSH) ? (ptr_ff - PTR_W'(1))
                                                : (ptr_ff + PTR_W'(1));
            k_in       = k_ff + CNT_W'(1);
            if (last_byte) begin
               state_in = is_read ? ST_DRAIN : ST_DONE;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = ok_ff ? STATUS_DONE : STATUS_REJECTED;
               rsp_in.read_data     = ok_ff ? rdata_ff : '0;
               rsp_in.new_stack_ptr = nsp_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         low_ff       <= '0;
         high_ff      <= PTR_W'(65535);
         lim_ff       <= LIM_W'(65536);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         lim_ff       <= lim_in;
      end
      kind_ff    <= kind_in;
      count_ff   <= count_in;
      addr_ff    <= addr_in;
      sp_ff      <= sp_in;
      fb_ff      <= fb_in;
      wdata_ff   <= wdata_in;
      ptr_ff     <= ptr_in;
      k_ff       <= k_in;
      rd_lane_ff <= rd_lane_in;
      rdata_ff   <= rdata_in;
      ok_ff      <= ok_in;
      nsp_ff     <= nsp_in;
      rsp_ff     <= rsp_in;
   end

   // Byte memory: one write, one registered read (old data on same address)
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wbyte;
      end
      mem_q_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the checked stack memory unit: shadow memory, stimulus, result checks.
`timescale 1ns / 1ps

module tb_top;
   import csmu_pkg::*;

   localparam int NUM_PHASES   = 10;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 400;

   // Shadow of the byte memory and limit registers; predicts and checks each transaction
   class stack_memory_shadow;
      logic [7:0]   mem_bytes [0:65535];
      int unsigned  low_limit;
      int unsigned  high_limit;
      int unsigned  mem_limit;
      csmu_rsp_type awaited_replies [$];
      int unsigned  errors;
      int unsigned  checked;
      int unsigned  done_by_kind [4];
      int unsigned  rejected_by_kind [4];

      function new();
         foreach (mem_bytes[i]) mem_bytes[i] = 8'h00;
         low_limit  = 0;
         high_limit = 65535;
         mem_limit  = 65536;
         errors     = 0;
         checked    = 0;
         foreach (done_by_kind[i]) begin
            done_by_kind[i]     = 0;
            rejected_by_kind[i] = 0;
         end
      endfunction

      function void write_limit(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_STACK_LOW:  low_limit  = value[15:0];
            REG_STACK_HIGH: high_limit = value[15:0];
            REG_MEM_LIMIT:  mem_limit  = value[16:0];
            default: ;
         endcase
      endfunction

      function bit frame_fits(int unsigned sp, int unsigned fb);
         return sp <= fb && sp >= low_limit && fb < high_limit;
      endfunction

      // Apply one accepted request to the shadow memory and queue its expected reply
      function csmu_rsp_type note_request(csmu_req_type r);
         csmu_rsp_type      res;
         bit                ok;
         int unsigned       sp, fb, cnt, addr, last, k;
         logic [15:0]       a;
         logic [DATA_W-1:0] rd;
         sp   = r.stack_ptr;
         fb   = r.frame_base;
         cnt  = r.byte_count;
         addr = r.address;
         ok   = cnt <= MAX_BYTES;
         rd   = '0;
         last = 0;
         if (ok) begin
            case (r.req_type)
               KIND_PUSH: begin
                  if (!frame_fits(sp, fb) || cnt > sp) begin
                     ok = 1'b0;
                  end else begin
                     last = sp - cnt;
                     if (last >= fb || last < low_limit) ok = 1'b0;
                  end
                  if (ok)
                     for (k = 0; k < cnt; k++) mem_bytes[16'(sp - k)] = r.write_data[8*k +: 8];
               end
               KIND_POP: begin
                  last = sp + cnt;
                  if (!frame_fits(sp, fb) || last > fb || last < low_limit ||
                      last > high_limit) begin
                     ok = 1'b0;
                  end else begin
                     // first byte read lands in the highest used lane
                     for (k = 0; k < cnt; k++) begin
                        a = 16'(sp + 1 + k);
                        rd[8*(cnt-1-k) +: 8] = mem_bytes[a];
                        mem_bytes[a] = 8'h00;
                     end
                  end
               end
               default: begin
                  last = addr + cnt;
                  if (last > mem_limit || last > MEM_DEPTH) begin
                     ok = 1'b0;
                  end else if (r.req_type == KIND_STORE) begin
                     for (k = 0; k < cnt; k++)
                        mem_bytes[16'(addr + k)] = r.write_data[8*k +: 8];
                  end else begin
                     for (k = 0; k < cnt; k++) rd[8*k +: 8] = mem_bytes[16'(addr + k)];
                  end
               end
            endcase
         end
         res.status    = ok ? STATUS_DONE : STATUS_REJECTED;
         res.read_data = ok ? rd : '0;
         if (ok && r.req_type == KIND_PUSH)     res.new_stack_ptr = 16'(sp - cnt);
         else if (ok && r.req_type == KIND_POP) res.new_stack_ptr = 16'(sp + cnt);
         else                                   res.new_stack_ptr = r.stack_ptr;
         if (ok) done_by_kind[r.req_type]++;
         else    rejected_by_kind[r.req_type]++;
         awaited_replies.push_back(res);
         return res;
      endfunction

      // Compare one accepted reply with the oldest awaited one
      function void check_reply(csmu_rsp_type got);
         csmu_rsp_type want;
         if (awaited_replies.size() == 0) begin
            $error("unexpected result transaction: status %0d read_data %0h new_stack_ptr %0h",
                   got.status, got.read_data, got.new_stack_ptr);
            errors++;
            return;
         end
         want = awaited_replies.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %016h, got %016h", want.read_data, got.read_data);
            errors++;
         end
         if (got.new_stack_ptr !== want.new_stack_ptr) begin
            $error("new_stack_ptr: expected %04h, got %04h", want.new_stack_ptr,
                   got.new_stack_ptr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   csmu_req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   csmu_rsp_type rsp_data;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   stack_memory_shadow sb = new();

   // stimulus state
   bit          idle_on = 1'b1;
   bit          stall_on = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned holds_done = 0;
   int unsigned csr_mismatches = 0;
   int unsigned cfg_low, cfg_high, cfg_limit;
   int unsigned cur_sp, cur_fb, store_base;

   checked_stack_memory_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_reply(rsp_data);
   end

   // receiver back-pressure: short random bursts, plus one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall = 1'b0;
            hold_request = 1'b0;
            holds_done++;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d results still outstanding", sb.awaited_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic csmu_req_type make_req(logic [1:0] kind, logic [63:0] data,
                                             logic [3:0] cnt, logic [15:0] addr,
                                             logic [15:0] sp, logic [15:0] fb);
      csmu_req_type r;
      r.req_type   = kind;
      r.write_data = data;
      r.byte_count = cnt;
      r.address    = addr;
      r.stack_ptr  = sp;
      r.frame_base = fb;
      return r;
   endfunction

   task automatic send_request(input csmu_req_type r, output csmu_rsp_type predicted);
      req_data  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = sb.note_request(r);
      @(negedge clock);
   endtask

   // lower valid and wait until every awaited reply has come and the block is quiet
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.awaited_replies.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic read_back(input logic [1:0] idx, input logic [31:0] want);
      logic [31:0] mask;
      mask    = (idx == REG_MEM_LIMIT) ? 32'h0001_FFFF : 32'h0000_FFFF;
      psel    = 1'b1;
      pwrite  = 1'b0;
      penable = 1'b0;
      paddr   = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (want & mask)) begin
         $error("register %0d readback: expected %0h, got %0h", idx, want & mask,
                prdata & mask);
         csr_mismatches++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_limit(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      read_back(idx, value);
   endtask

   // open a fresh frame inside the configured stack window, or anywhere when the window is too narrow
   task automatic new_frame();
      int unsigned top;
      if (cfg_high >= cfg_low + 24) begin
         top = cfg_high - 1;
         if (top > cfg_low + 700) top = cfg_low + 700;
         cur_fb = $urandom_range(cfg_low + 16, top);
      end else begin
         cur_fb = $urandom_range(0, 65535);
      end
      cur_sp = cur_fb;
   endtask

   // mostly well-formed stack traffic around the current frame, some broken items and noise
   task automatic make_item(output csmu_req_type r);
      int unsigned pick, room;
      r.write_data = {$urandom, $urandom};
      r.address    = 16'($urandom);
      r.stack_ptr  = 16'(cur_sp);
      r.frame_base = 16'(cur_fb);
      r.byte_count = 4'($urandom_range(1, 8));
      if ($urandom_range(0, 15) == 0) r.byte_count = '0;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         if (cur_sp > cfg_low + 24) cur_fb = cur_sp;
         r.frame_base = 16'(cur_fb);
      end else if (pick < 5 || (cur_sp < cfg_low + 9 && cur_sp == cur_fb)) begin
         new_frame();
         r.stack_ptr  = 16'(cur_sp);
         r.frame_base = 16'(cur_fb);
      end
      pick = $urandom_range(0, 99);
      if (pick < 36 && cur_sp < cfg_low + 9) pick = 40;
      if (pick < 36) begin
         r.req_type = KIND_PUSH;
      end else if (pick < 66) begin
         r.req_type = KIND_POP;
         room = cur_fb - cur_sp;
         r.byte_count = 4'($urandom_range(0, room < 8 ? room : 8));
      end else if (pick < 80) begin
         r.req_type = ($urandom_range(0, 1) == 0) ? KIND_STORE : KIND_LOAD;
         case ($urandom_range(0, 7))
            0:       r.address = 16'(cfg_limit - $urandom_range(0, 12));
            1, 2:    r.address = 16'(cur_sp + 1);
            default: r.address = 16'(store_base + $urandom_range(0, 63));
         endcase
      end else if (pick < 90) begin
         // slightly wrong pointers or oversized counts
         r.req_type   = 2'($urandom_range(0, 3));
         r.byte_count = 4'($urandom_range(0, 15));
         r.stack_ptr  = 16'(cur_sp + $urandom_range(0, 4) - 2);
         r.frame_base = 16'(cur_fb + $urandom_range(0, 2) - 1);
      end else begin
         r.req_type   = 2'($urandom);
         r.byte_count = 4'($urandom);
         r.stack_ptr  = 16'($urandom);
         r.frame_base = 16'($urandom);
      end
   endtask

   task automatic pick_setting(input int p, output int unsigned items);
      items = 170;
      case (p)
         0: begin cfg_low = 0;      cfg_high = 65535;  cfg_limit = 65536;   end
         1: begin cfg_low = 'h1000; cfg_high = 'h1400; cfg_limit = 'h2000;  end
         2: begin cfg_low = 0;      cfg_high = 0;      cfg_limit = 0;       items = 60; end
         3: begin cfg_low = 'hFFFF; cfg_high = 'hFFFF; cfg_limit = 'h1FFFF; items = 60; end
         4: begin cfg_low = 'hFF00; cfg_high = 'hFFFF; cfg_limit = 'hFFF0;  end
         default: begin
            cfg_low   = $urandom_range(0, 'hF000);
            cfg_high  = cfg_low + $urandom_range(32, 'h0FFF);
            cfg_limit = $urandom_range(0, 65536);
         end
      endcase
   endtask

   initial begin
      csmu_req_type directed [$];
      csmu_req_type r;
      csmu_rsp_type predicted;
      int unsigned  items, eff_limit;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // limit registers hold their reset values
      read_back(REG_STACK_LOW, 32'd0);
      read_back(REG_STACK_HIGH, 32'd65535);
      read_back(REG_MEM_LIMIT, 32'd65536);

      // directed cases under reset limits
      directed = '{
         make_req(KIND_PUSH,  64'h8877_6655_4433_2211, 8, 0,       'h0200, 'h0300),
         make_req(KIND_POP,   64'h0,                  8, 0,       'h01F8, 'h0300),
         make_req(KIND_POP,   64'h0,                  8, 0,       'h01F8, 'h0300),
         make_req(KIND_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 8, 0,      'h0200, 'h0200),
         make_req(KIND_PUSH,  64'h0,                  0, 0,       'h0200, 'h0200),
         make_req(KIND_PUSH,  64'h0,                  0, 0,       'h01FF, 'h0200),
         make_req(KIND_PUSH,  64'h1,                  9, 0,       'h0100, 'h0200),
         make_req(KIND_STORE, 64'h1,                  15, 0,      'h0100, 'h0200),
         make_req(KIND_PUSH,  64'h2,                  2, 0,       'h0300, 'h0200),
         make_req(KIND_PUSH,  64'h3,                  2, 0,       'h0100, 'hFFFF),
         make_req(KIND_PUSH,  64'h4,                  4, 0,       'h0003, 'h0010),
         make_req(KIND_PUSH,  64'hA5A5_5A5A_C3C3_3C3C, 8, 0,      'h0008, 'h0010),
         make_req(KIND_POP,   64'h0,                  8, 0,       'h01F8, 'h01FC),
         make_req(KIND_POP,   64'h0,                  0, 0,       'h01F8, 'h0200),
         make_req(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8, 'h0000, 'h0000, 'h0000),
         make_req(KIND_LOAD,  64'h0,                  8, 'h0000,  'h0000, 'h0000),
         make_req(KIND_STORE, 64'h0123_4567_89AB_CDEF, 8, 'hFFF8, 'hFFFF, 'hFFFF),
         make_req(KIND_LOAD,  64'h0,                  8, 'hFFF8,  'hFFFF, 'hFFFF),
         make_req(KIND_STORE, 64'h5,                  8, 'hFFF9,  'h0000, 'h0000),
         make_req(KIND_LOAD,  64'h0,                  1, 'hFFFF,  'h0000, 'h0000),
         make_req(KIND_LOAD,  64'h0,                  0, 'hFFFF,  'h0000, 'h0000),
         make_req(KIND_LOAD,  64'h0,                  8, 'h01F9,  'h0000, 'h0000),
         make_req(KIND_POP,   64'h0,                  8, 0,       'h01F8, 'h0200),
         make_req(KIND_POP,   64'h0,                  8, 0,       'h0000, 'h0010)
      };
      foreach (directed[i]) begin
         send_request(directed[i], predicted);
         if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
      end

      // random traffic under a series of limit settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         pick_setting(p, items);
         write_reg(REG_STACK_LOW, cfg_low);
         write_reg(REG_STACK_HIGH, cfg_high);
         write_reg(REG_MEM_LIMIT, cfg_limit);
         new_frame();
         eff_limit  = (cfg_limit > 65536) ? 65536 : cfg_limit;
         store_base = (eff_limit >= 80) ? $urandom_range(0, eff_limit - 72) : 0;
         for (int i = 0; i < items; i++) begin
            if (i % 64 == 0) begin
               idle_on  = (p != NUM_PHASES - 1) && $urandom_range(0, 2) != 0;
               stall_on = (p != NUM_PHASES - 1) && $urandom_range(0, 2) != 0;
            end
            // receiver holds off while items keep coming
            if (p == 1 && i == 40) hold_request = 1'b1;
            // sender pauses until everything is back
            if (p == 5 && i == 90) wait_drained();
            make_item(r);
            send_request(r, predicted);
            if (predicted.status == STATUS_DONE && r.stack_ptr == 16'(cur_sp) &&
                r.frame_base == 16'(cur_fb) &&
                (r.req_type == KIND_PUSH || r.req_type == KIND_POP))
               cur_sp = predicted.new_stack_ptr;
            if (idle_on && $urandom_range(0, 5) == 0) begin
               req_valid = 1'b0;
               repeat ($urandom_range(1, 5)) @(negedge clock);
            end
         end
      end

      wait_drained();
      $display("Checked %0d results: push %0d done/%0d rejected, pop %0d/%0d, store %0d/%0d, load %0d/%0d",
               sb.checked, sb.done_by_kind[KIND_PUSH], sb.rejected_by_kind[KIND_PUSH],
               sb.done_by_kind[KIND_POP], sb.rejected_by_kind[KIND_POP],
               sb.done_by_kind[KIND_STORE], sb.rejected_by_kind[KIND_STORE],
               sb.done_by_kind[KIND_LOAD], sb.rejected_by_kind[KIND_LOAD]);
      $display("%0d limit settings, %0d long receiver hold(s), %0d register readback mismatches",
               NUM_PHASES, holds_done, csr_mismatches);
      if (sb.errors == 0 && csr_mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
